>>> hdl/fpdtf_pkg.sv
// fpdtf_pkg: shared types and constants for the fixed-point decimal text formatter
// used by fpdtf_unit and fixed_point_decimal_text_formatter; depends on nothing
`default_nettype none

package fpdtf_pkg;

	localparam int FRACTION_DIGITS = 8;
	localparam int SCREEN_COLUMNS  = 80;

	// integer part of a Q16.16 magnitude is at most 32768: five decimal digits
	localparam int INT_DIGITS = 5;
	localparam int ND_W       = $clog2(INT_DIGITS + 1);
	localparam int FCNT_W     = $clog2(FRACTION_DIGITS + 1);

	localparam int VALUE_W     = 32;
	localparam int DATA_W      = 16;
	localparam int DIGIT_W     = 4;
	localparam int ROW_W       = 5;
	localparam int COL_W       = 7;
	localparam int CHAR_W      = 7;
	localparam int ADDR_W      = 12;
	localparam int ADDR_CALC_W = 14;

	// x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
	localparam logic [DATA_W-1:0] RECIP10     = 16'hCCCD;
	localparam int                RECIP_SHIFT = 19;
	localparam logic [DATA_W-1:0] TEN         = 16'd10;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;

	typedef enum logic {
		OP_DIV10,
		OP_MUL10
	} unit_op_t;

	typedef struct packed {
		logic [DATA_W-1:0]  word;
		logic [DIGIT_W-1:0] digit;
	} unit_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_INT,
		ST_POINT,
		ST_FRAC
	} state_t;

endpackage

`default_nettype wire

>>> hdl/fixed_point_decimal_text_formatter.sv
// fixed_point_decimal_text_formatter: Q16.16 value to ASCII characters with text cell addresses
// depends on fpdtf_pkg and fpdtf_unit
//
// channel   direction  handshake                     payload
// command   in         start & !busy                 value, screen_row, start_column
// result    out        strobe (one cycle, no stall)  character_code, cell_address, last
//
// a transaction emits an optional minus sign, 1 to 5 integer digits, the point and
// FRACTION_DIGITS fraction digits; the next command is accepted only once back in idle
// integer digits come from one divide-by-ten pass per digit through the shared multiply unit,
// then one character per cycle; fraction digits reuse the unit as a times-ten step
// arst_n clears the sequencer and the strobe; results cannot be held off by the receiver
`default_nettype none

module fixed_point_decimal_text_formatter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [fpdtf_pkg::VALUE_W-1:0] value,
	input  logic [fpdtf_pkg::ROW_W-1:0]         screen_row,
	input  logic [fpdtf_pkg::COL_W-1:0]         start_column,
	output logic                                busy,
	output logic                                strobe,
	output logic [fpdtf_pkg::CHAR_W-1:0]        character_code,
	output logic [fpdtf_pkg::ADDR_W-1:0]        cell_address,
	output logic                                last
);
	import fpdtf_pkg::*;

	state_t state_q, state_d;

	logic                neg_q;
	logic [DATA_W-1:0]   ipart_q;
	logic [DATA_W-1:0]   frac_q;
	logic [DIGIT_W-1:0]  dig_q [INT_DIGITS];
	logic [ND_W-1:0]     nd_q;
	logic [FCNT_W-1:0]   fcnt_q;
	logic [ADDR_W-1:0]   addr_q;
	logic                strobe_q;
	logic                last_q;
	logic [CHAR_W-1:0]   char_q;
	logic [ADDR_W-1:0]   addr_out_q;

	logic                accept;
	logic [VALUE_W-1:0]  value_u;
	logic [VALUE_W-1:0]  mag;
	logic [ADDR_CALC_W-1:0] base_full;
	logic                fcnt_last;
	logic                conv_done;

	unit_op_t            u_op;
	logic [DATA_W-1:0]   u_operand;
	unit_res_t           u_res;

	logic                emit;
	logic                emit_last;
	logic [CHAR_W-1:0]   emit_char;

	assign accept    = (state_q == ST_IDLE) && start;
	assign value_u   = $unsigned(value);
	assign mag       = value_u[VALUE_W-1] ? (VALUE_W'(0) - value_u) : value_u;
	assign base_full = (ADDR_CALC_W'(screen_row) * ADDR_CALC_W'(SCREEN_COLUMNS)
	                   + ADDR_CALC_W'(start_column)) << 1;
	assign fcnt_last = (fcnt_q == FCNT_W'(FRACTION_DIGITS - 1));
	assign conv_done = (u_res.word == '0) || (nd_q == ND_W'(INT_DIGITS - 1));

	fpdtf_unit u_unit (
		.op      (u_op),
		.operand (u_operand),
		.res     (u_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_CONV;
			ST_CONV:  if (conv_done) state_d = neg_q ? ST_SIGN : ST_INT;
			ST_SIGN:  state_d = ST_INT;
			ST_INT:   if (nd_q == ND_W'(1)) state_d = ST_POINT;
			ST_POINT: state_d = ST_FRAC;
			ST_FRAC:  if (fcnt_last) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		u_op      = OP_DIV10;
		u_operand = ipart_q;
		emit      = 1'b0;
		emit_last = 1'b0;
		emit_char = CH_ZERO;
		unique case (state_q)
			ST_IDLE, ST_CONV: begin
			end
			ST_SIGN: begin
				emit      = 1'b1;
				emit_char = CH_MINUS;
			end
			ST_INT: begin
				emit      = 1'b1;
				emit_char = CH_ZERO + CHAR_W'(dig_q[0]);
			end
			ST_POINT: begin
				emit      = 1'b1;
				emit_char = CH_POINT;
			end
			ST_FRAC: begin
				u_op      = OP_MUL10;
				u_operand = frac_q;
				emit      = 1'b1;
				emit_last = fcnt_last;
				emit_char = CH_ZERO + CHAR_W'(u_res.digit);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			nd_q     <= '0;
			fcnt_q   <= '0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			last_q   <= emit_last;
			if (accept) begin
				nd_q   <= '0;
				fcnt_q <= '0;
			end else if (state_q == ST_CONV) begin
				nd_q <= nd_q + ND_W'(1);
			end else if (state_q == ST_INT) begin
				nd_q <= nd_q - ND_W'(1);
			end else if (state_q == ST_FRAC) begin
				fcnt_q <= fcnt_q + FCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q   <= value_u[VALUE_W-1];
			ipart_q <= DATA_W'(mag >> DATA_W);
			frac_q  <= mag[DATA_W-1:0];
			addr_q  <= base_full[ADDR_W-1:0];
		end
		// remainders enter at the bottom, so the leading digit ends up in entry 0
		if (state_q == ST_CONV) begin
			ipart_q  <= u_res.word;
			dig_q[0] <= u_res.digit;
			for (int i = 1; i < INT_DIGITS; i++) begin
				dig_q[i] <= dig_q[i-1];
			end
		end else if (state_q == ST_INT) begin
			for (int i = 0; i < INT_DIGITS - 1; i++) begin
				dig_q[i] <= dig_q[i+1];
			end
		end
		if (state_q == ST_FRAC) begin
			frac_q <= u_res.word;
		end
		if (emit) begin
			addr_q     <= addr_q + ADDR_W'(2);
			char_q     <= emit_char;
			addr_out_q <= addr_q;
		end
	end

	assign busy           = (state_q != ST_IDLE);
	assign strobe         = strobe_q;
	assign last           = last_q;
	assign character_code = char_q;
	assign cell_address   = addr_out_q;

	a_last_with_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe)
		else $error("last flag without a result strobe");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_int_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INT) |-> ((nd_q != '0) && (nd_q <= ND_W'(INT_DIGITS))))
		else $error("integer digit count out of range while emitting");

	a_frac_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FRAC && fcnt_last) |=> (last && strobe && state_q == ST_IDLE))
		else $error("final fraction digit not flagged or sequencer not idle");

	a_point_char: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POINT) |=> (strobe && character_code == CH_POINT))
		else $error("decimal point not emitted");

endmodule

`default_nettype wire

>>> hdl/fpdtf_unit.sv
// fpdtf_unit: shared multiply unit, divides by ten (quotient, remainder)
// or multiplies a 16-bit fraction by ten (digit, new fraction); uses fpdtf_pkg
`default_nettype none

module fpdtf_unit (
	input  fpdtf_pkg::unit_op_t           op,
	input  logic [fpdtf_pkg::DATA_W-1:0]  operand,
	output fpdtf_pkg::unit_res_t          res
);
	import fpdtf_pkg::*;

	logic [DATA_W-1:0]   mult_b;
	logic [2*DATA_W-1:0] prod;
	logic [DATA_W-1:0]   quot;
	logic [DATA_W-1:0]   quot_x10;

	assign prod     = (2*DATA_W)'(operand) * (2*DATA_W)'(mult_b);
	assign quot     = DATA_W'(prod >> RECIP_SHIFT);
	// times ten by shift and add
	assign quot_x10 = (quot << 3) + (quot << 1);

	always_comb begin
		unique case (op)
			OP_DIV10: mult_b = RECIP10;
			OP_MUL10: mult_b = TEN;
			default:  mult_b = RECIP10;
		endcase
	end

	always_comb begin
		unique case (op)
			OP_DIV10: begin
				res.word  = quot;
				res.digit = DIGIT_W'(operand - quot_x10);
			end
			OP_MUL10: begin
				res.word  = prod[DATA_W-1:0];
				res.digit = prod[DATA_W +: DIGIT_W];
			end
			default: begin
				res.word  = quot;
				res.digit = DIGIT_W'(operand - quot_x10);
			end
		endcase
	end

endmodule

`default_nettype wire
